// File: rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants for the bitmap range-set block.
// ----------------------------------------------------------------------------
package brs_pkg;

    // fixed field widths of the item and result words
    localparam int FIRST_W = 12;
    localparam int END_W   = 13;
    localparam int IDX_W   = 7;
    localparam int DATA_W  = 32;

    // action codes
    localparam logic [1:0] ACT_SET_RANGE = 2'd0;
    localparam logic [1:0] ACT_SET_BIT   = 2'd1;
    localparam logic [1:0] ACT_READ      = 2'd2;

    // result kinds
    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_RD,
        ST_WR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div;
        logic rem;
        logic rd;
        logic wr;
        logic clr;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_mem;
        logic is_write;
        logic last_word;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/brs_ram.sv
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/brs_ctrl.sv
// ----------------------------------------------------------------------------
// brs_ctrl
// Sequencer: clearing pass, index split, read-modify-write walk, result.
// ----------------------------------------------------------------------------
module brs_ctrl
    import brs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DIV;
            end
            ST_DIV: n_state = ST_REM;
            ST_REM: begin
                n_state = i_sts.need_mem ? ST_RD : ST_OUT;
            end
            ST_RD: n_state = ST_WR;
            ST_WR: begin
                if (i_sts.is_write && !i_sts.last_word) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_DIV:   o_cmd.div = 1'b1;
            ST_REM:   o_cmd.rem = 1'b1;
            ST_RD:    o_cmd.rd  = 1'b1;
            ST_WR:    o_cmd.wr  = 1'b1;
            ST_OUT:   o_cmd.emit = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/brs_dp.sv
// ----------------------------------------------------------------------------
// brs_dp
// Datapath: bit index split, word masks, bitmap RAM and result register.
// ----------------------------------------------------------------------------
module brs_dp
    import brs_pkg::*;
#(
    parameter int BITMAP_WORDS = 128,
    parameter int WORD_BITS    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [1:0]         i_action,
    input  logic [FIRST_W-1:0] i_first_bit,
    input  logic [END_W-1:0]   i_end_bit,
    input  logic [IDX_W-1:0]   i_word_index,
    input  logic               i_out_stall,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output logic               o_result_kind,
    output logic [DATA_W-1:0]  o_word_data
);

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int OW = $clog2(WORD_BITS);
    localparam int unsigned TOTAL_BITS = BITMAP_WORDS * WORD_BITS;
    // exact divide by WORD_BITS for any END_W-bit value via reciprocal multiply
    localparam int SH    = END_W + OW;
    localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int MW    = $clog2(RECIP + 1);
    localparam int PW    = END_W + MW;
    localparam logic [END_W-1:0]     W_N  = END_W'(WORD_BITS);
    localparam logic [WORD_BITS-1:0] FULL = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] ONE  = WORD_BITS'(1);
    localparam logic [OW-1:0]        TOP  = OW'(WORD_BITS - 1);
    localparam logic [AW-1:0]        LAST = AW'(BITMAP_WORDS - 1);

    logic [END_W-1:0]     r_xa;
    logic [END_W-1:0]     r_xb;
    logic                 r_range_ok;
    logic                 r_bit_ok;
    logic                 r_read;
    logic                 r_read_ok;
    logic [IDX_W-1:0]     r_idx;
    logic [END_W-1:0]     r_qa;
    logic [END_W-1:0]     r_qb;
    logic [OW-1:0]        r_ra;
    logic [OW-1:0]        r_rb;
    logic [AW-1:0]        r_w;
    logic [AW-1:0]        r_fw;
    logic [AW-1:0]        r_lw;
    logic [DATA_W-1:0]    r_res_data;
    logic                 r_kind;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    logic                 r_out_kind;

    logic [END_W-1:0]     end_sat;
    logic [PW-1:0]        prod_a;
    logic [PW-1:0]        prod_b;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] rdata;
    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 is_write;

    assign end_sat = (32'(i_end_bit) > TOTAL_BITS) ? END_W'(TOTAL_BITS) : i_end_bit;
    assign prod_a  = PW'(r_xa) * PW'(RECIP);
    assign prod_b  = PW'(r_xb) * PW'(RECIP);
    assign is_write = r_range_ok | r_bit_ok;

    always_comb begin
        if (r_bit_ok) begin
            mask = ONE << r_ra;
        end else begin
            mask = ((r_w == r_fw) ? (FULL << r_ra) : FULL)
                 & ((r_w == r_lw) ? (FULL >> (TOP - r_rb)) : FULL);
        end
    end

    assign ram_we    = i_cmd.clr | (i_cmd.wr & is_write);
    assign ram_wdata = i_cmd.clr ? '0 : (rdata | mask);

    brs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_w),
        .i_wdata (ram_wdata),
        .i_raddr (r_w),
        .o_rdata (rdata)
    );

    // word pointer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_w <= (r_w == LAST) ? '0 : AW'(r_w + 1'b1);
            end else if (i_cmd.rem) begin
                r_w <= r_read ? AW'(r_idx) : AW'(r_qa);
            end else if (i_cmd.wr && is_write && (r_w != r_lw)) begin
                r_w <= AW'(r_w + 1'b1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xa       <= END_W'(i_first_bit);
            r_xb       <= end_sat - 1'b1;
            r_range_ok <= (i_action == ACT_SET_RANGE) && (END_W'(i_first_bit) < end_sat);
            r_bit_ok   <= (i_action == ACT_SET_BIT) && (32'(i_first_bit) < TOTAL_BITS);
            r_read     <= (i_action == ACT_READ);
            r_read_ok  <= (32'(i_word_index) < BITMAP_WORDS);
            r_idx      <= i_word_index;
            r_kind     <= (i_action == ACT_READ) ? KIND_READ : KIND_SET;
            r_res_data <= '0;
        end
        if (i_cmd.div) begin
            r_qa <= END_W'(prod_a >> SH);
            r_qb <= END_W'(prod_b >> SH);
        end
        if (i_cmd.rem) begin
            r_ra <= OW'(r_xa - r_qa * W_N);
            r_rb <= OW'(r_xb - r_qb * W_N);
            r_fw <= AW'(r_qa);
            r_lw <= r_bit_ok ? AW'(r_qa) : AW'(r_qb);
        end
        if (i_cmd.wr && r_read) begin
            r_res_data <= DATA_W'(rdata);
        end
        if (i_cmd.emit) begin
            r_out_kind <= r_kind;
            r_out_data <= r_res_data;
        end
    end

    assign o_sts.clr_last  = (r_w == LAST);
    assign o_sts.need_mem  = is_write | (r_read & r_read_ok);
    assign o_sts.is_write  = is_write;
    assign o_sts.last_word = (r_w == r_lw);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_word_data   = r_out_data;

    // a range walk stays between its first and last word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && r_range_ok) |-> (r_w >= r_fw && r_w <= r_lw))
        else $error("range write outside covered words");

    // a result is never loaded over one that is still stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // memory accesses stay inside the bitmap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd || i_cmd.wr) |-> (32'(r_w) < BITMAP_WORDS))
        else $error("bitmap address out of range");

    // a read result comes out tagged as read data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_read) |=> (r_out_kind == KIND_READ))
        else $error("read result with wrong kind");

endmodule

// File: rtl/bitmap_range_set_top.sv
// ----------------------------------------------------------------------------
// bitmap_range_set_top
// Allocation bitmap with range set, single bit set and word read.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one word of i_action,
// i_first_bit, i_end_bit and i_word_index. Output channel: o_out_valid /
// i_out_stall carry o_result_kind and o_word_data; every word in gives
// exactly one word out (kind 1 with data for a read, kind 0 and zero data
// otherwise).
// One word is worked on at a time. The index split is a reciprocal
// multiply, then the remainder; each bitmap word touched then takes a
// registered RAM read and the write back. An empty range, a bad index
// or an unused action goes straight to the result.
// After reset the RAM is swept to zero, one word a cycle, over all
// BITMAP_WORDS words; o_in_stall stays high until the sweep is done.
// The result sits in an output register: a stalled receiver holds it there
// and the next word is still accepted, but its result waits for the
// register to free up.
// ----------------------------------------------------------------------------
module bitmap_range_set_top
    import brs_pkg::*;
#(
    parameter int BITMAP_WORDS = 128,
    parameter int WORD_BITS    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [FIRST_W-1:0] i_first_bit,
    input  logic [END_W-1:0]   i_end_bit,
    input  logic [IDX_W-1:0]   i_word_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_result_kind,
    output logic [DATA_W-1:0]  o_word_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    brs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    brs_dp #(
        .BITMAP_WORDS (BITMAP_WORDS),
        .WORD_BITS    (WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_first_bit   (i_first_bit),
        .i_end_bit     (i_end_bit),
        .i_word_index  (i_word_index),
        .i_out_stall   (i_out_stall),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_word_data   (o_word_data)
    );

endmodule

// File: bench/bitmap_range_set_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_range_set_top_tb
// Self-checking bench for the allocation bitmap: drives set-range, set-bit,
// read and unused-action words under random idle and stall patterns, keeps
// its own copy of the bitmap and compares every result word in order.
// ----------------------------------------------------------------------------
module bitmap_range_set_top_tb;
    import brs_pkg::*;

    localparam int          MAP_WORDS   = 128;
    localparam int          MAP_BITS    = MAP_WORDS * 32;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam int          STALL_LIMIT = 20000;
    localparam int          TAIL_CYCLES = 300;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] data;
    } t_word_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_action;
    logic [FIRST_W-1:0] i_first_bit;
    logic [END_W-1:0]   i_end_bit;
    logic [IDX_W-1:0]   i_word_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_result_kind;
    logic [DATA_W-1:0]  o_word_data;

    logic [31:0]  shadow_map [MAP_WORDS];
    t_word_result expected_words [$];
    int           mismatch_count = 0;
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int           stall_hold     = 0;
    int           quiet_cycles   = 0;

    bitmap_range_set_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_first_bit   (i_first_bit),
        .i_end_bit     (i_end_bit),
        .i_word_index  (i_word_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_word_data   (o_word_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // applies one word to the shadow bitmap and returns the result it causes
    function automatic void predict_word(input logic [1:0] act,
                                         input logic [FIRST_W-1:0] fb,
                                         input logic [END_W-1:0] eb,
                                         input logic [IDX_W-1:0] wi,
                                         output t_word_result res);
        int unsigned lim, fw, lw, w, rem;
        logic [31:0] mask;
        res.kind = KIND_SET;
        res.data = '0;
        case (act)
            ACT_SET_RANGE: begin
                lim = (eb > MAP_BITS) ? MAP_BITS : eb;
                if (fb < lim) begin
                    fw = fb / 32;
                    lw = (lim - 1) / 32;
                    for (w = fw; w <= lw; w++) begin
                        mask = '1;
                        if (w == fw)
                            mask &= ~((32'd1 << (fb % 32)) - 32'd1);
                        rem = lim - w * 32;
                        if (w == lw && rem < 32)
                            mask &= (32'd1 << rem) - 32'd1;
                        shadow_map[w] |= mask;
                    end
                end
            end
            ACT_SET_BIT: begin
                shadow_map[fb / 32][fb % 32] = 1'b1;
            end
            ACT_READ: begin
                res.kind = KIND_READ;
                res.data = shadow_map[wi];
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, field, want, got);
    endtask

    task automatic send_word(input logic [1:0] act, input logic [FIRST_W-1:0] fb,
                             input logic [END_W-1:0] eb, input logic [IDX_W-1:0] wi);
        t_word_result want;
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_first_bit  <= fb;
        i_end_bit    <= eb;
        i_word_index <= wi;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(act, fb, eb, wi, want);
        expected_words.push_back(want);
    endtask

    // drop valid first so the last word is not taken a second time
    task automatic drain_results;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // random word; sets are kept sparse so the bitmap does not saturate early
    task automatic send_random_word;
        int unsigned pick, fb, eb;
        logic [1:0] act;
        pick = $urandom_range(99);
        fb   = $urandom_range(MAP_BITS - 1);
        eb   = $urandom_range(8191);
        act  = ACT_READ;
        if (pick < 35) begin
            act = ACT_READ;
        end else if (pick < 65) begin
            act = ACT_SET_BIT;
        end else if (pick < 80) begin
            act = ACT_SET_RANGE;
            eb  = fb + $urandom_range(12);
        end else if (pick < 81) begin
            act = ACT_SET_RANGE;
            eb  = fb + $urandom_range(96);
        end else if (pick < 87) begin
            // end at or past the map size, saturates
            act = ACT_SET_RANGE;
            fb  = MAP_BITS - 32 + $urandom_range(31);
            eb  = $urandom_range(8191, MAP_BITS);
        end else if (pick < 96) begin
            // empty or reversed range
            act = ACT_SET_RANGE;
            eb  = $urandom_range(fb);
        end else begin
            act = ACT_UNUSED;
        end
        send_word(act, fb[FIRST_W-1:0], eb[END_W-1:0], IDX_W'($urandom_range(MAP_WORDS - 1)));
    endtask

    task automatic test_directed_cases;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(ACT_READ,      12'd0,    13'd0,    7'd0);
        send_word(ACT_SET_BIT,   12'd0,    13'd8191, 7'd127);
        send_word(ACT_SET_BIT,   12'd4095, 13'd0,    7'd0);
        send_word(ACT_READ,      12'd4095, 13'd8191, 7'd0);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd127);
        // both ends in one word
        send_word(ACT_SET_RANGE, 12'd5,    13'd20,   7'd0);
        // end on a word boundary must leave the next word alone
        send_word(ACT_SET_RANGE, 12'd40,   13'd64,   7'd0);
        send_word(ACT_SET_RANGE, 12'd94,   13'd130,  7'd0);
        send_word(ACT_SET_RANGE, 12'd200,  13'd200,  7'd0);
        send_word(ACT_SET_RANGE, 12'd300,  13'd250,  7'd0);
        send_word(ACT_SET_RANGE, 12'd4090, 13'd8191, 7'd0);
        send_word(ACT_UNUSED,    12'd4095, 13'd8191, 7'd127);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd0);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd1);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd2);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd3);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd4);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd6);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd9);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd127);
    endtask

    task automatic test_backpressure;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(posedge i_clk);
        stall_hold = 500;
        repeat (16) send_random_word();
        // sender waits for the block to empty out completely
        drain_results();
        repeat (8) send_random_word();
        drain_results();
    endtask

    task automatic test_random_traffic;
        int unsigned idle_set [4] = '{0, 86, 0, 33};
        int unsigned stall_set [4] = '{0, 0, 86, 33};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = idle_set[p];
            sink_stall_pct = stall_set[p];
            repeat (250) send_random_word();
        end
    endtask

    task automatic test_full_span;
        src_idle_pct   = 33;
        sink_stall_pct = 33;
        send_word(ACT_SET_RANGE, 12'd0,    13'd4096, 7'd0);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd0);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd64);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd127);
        send_word(ACT_SET_RANGE, 12'd0,    13'd8191, 7'd0);
        send_word(ACT_SET_BIT,   12'd2048, 13'd0,    7'd0);
        send_word(ACT_READ,      12'd0,    13'd0,    7'd64);
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                stall_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_word_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                flag_mismatch("unexpected word", 32'd0, o_word_data);
            end else begin
                want = expected_words.pop_front();
                if (o_result_kind !== want.kind)
                    flag_mismatch("result_kind", 32'(want.kind), 32'(o_result_kind));
                if (o_word_data !== want.data)
                    flag_mismatch("word_data", want.data, o_word_data);
            end
        end
    end

    // nothing moving on either side for too long means the block hung
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("bitmap_range_set_top verification failed");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < MAP_WORDS; w++)
            shadow_map[w] = '0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_action     = ACT_READ;
        i_first_bit  = '0;
        i_end_bit    = '0;
        i_word_index = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_backpressure();
        test_random_traffic();
        test_full_span();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("bitmap_range_set_top verification clean");
        else
            $display("bitmap_range_set_top verification failed");
        $finish;
    end

endmodule
